/* design/dts_pkg.sv */
package dts_pkg;

  localparam int SLOT_MAX_W = 6;
  localparam int FIRE_W = 7;
  localparam int RESULT_CAP = 16;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_DEL = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [2:0] STAT_ADDED = 3'd0;
  localparam logic [2:0] STAT_FAIL = 3'd1;
  localparam logic [2:0] STAT_DELETED = 3'd2;
  localparam logic [2:0] STAT_FIRED = 3'd3;
  localparam logic [2:0] STAT_NONE = 3'd4;

  typedef enum logic [1:0] {
    CMD_IDLE,
    CMD_ADD,
    CMD_DEL,
    CMD_SUB
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic [SLOT_MAX_W-1:0] sel;
    logic [7:0] code;
    logic [31:0] delay;
    logic [31:0] period;
    logic [31:0] least;
  } cell_cmd_t;

  // Token carried from cell to cell, one cell per cycle.
  typedef struct packed {
    logic tok;
    logic hit;
    logic any;
    logic [SLOT_MAX_W-1:0] idx;
    logic [31:0] least;
    logic [FIRE_W-1:0] fires;
  } link_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUB,
    ST_COUNT,
    ST_REPORT,
    ST_RESULT
  } state_t;

endpackage

/* design/delta_task_scheduler.sv */
// Task scheduler built as a row of SLOT_COUNT slot cells. Each cell keeps one
// task (code, remaining delay, reload period) and passes a token to its
// neighbor every cycle. An add sends a search token down the row; a delete
// answers without a scan. A time check runs a minimum search down the row,
// and if due, a subtract step, a fire count down the row and a scan that
// emits the fired tasks one at a time, in ascending slot order, waiting on any
// output stall. One input is handled at a time; in_stall is high while an item
// is in work. At most 16 fires are reported per time check; last_result marks
// the final result of each input.
module delta_task_scheduler #(
  parameter int SLOT_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_task_code,
  input  logic [31:0] in_first_delay,
  input  logic [31:0] in_repeat_period,
  input  logic [3:0]  in_slot_index,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_slot_out,
  output logic [7:0]  out_code_out,
  output logic        out_last_result
);
  import dts_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [CW-1:0] CNT_END = CW'(SLOT_COUNT);

  link_t             link_w [SLOT_COUNT];
  link_t             head;
  link_t             tail;
  cell_cmd_t         cmd;
  logic [SLOT_COUNT-1:0] fire_vec;
  logic [7:0]        code_vec [SLOT_COUNT];

  state_t      state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]  func_r, func_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [31:0] delay_r, delay_nxt;
  logic [31:0] period_r, period_nxt;
  logic [31:0] now_r, now_nxt;
  logic [31:0] least_r, least_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  logic [4:0]  total_r, total_nxt;
  logic [4:0]  sent_r, sent_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [2:0]  res_stat_r, res_stat_nxt;
  logic [3:0]  res_slot_r, res_slot_nxt;
  logic        ov_r, ov_nxt;
  logic [2:0]  os_r, os_nxt;
  logic [3:0]  oslot_r, oslot_nxt;
  logic [7:0]  ocode_r, ocode_nxt;
  logic        olast_r, olast_nxt;
  logic        accept;
  logic        out_free;
  logic        last_one;

  assign head = '{tok: (state_r == ST_SCAN && func_r == FUNC_ADD && cnt_r == '0),
                  default: '0};
  assign tail = link_w[SLOT_COUNT-1];

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    dts_cell #(.IDX(i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .link_i ((i == 0) ? head : link_w[(i == 0) ? 0 : i - 1]),
      .link_o (link_w[i]),
      .fire_o (fire_vec[i]),
      .code_o (code_vec[i])
    );
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !ov_r || !out_stall;
  assign last_one = (5'(sent_r + 5'd1) == total_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    func_nxt      = func_r;
    code_nxt      = code_r;
    delay_nxt     = delay_r;
    period_nxt    = period_r;
    now_nxt       = now_r;
    least_nxt     = least_r;
    last_time_nxt = last_time_r;
    total_nxt     = total_r;
    sent_nxt      = sent_r;
    ptr_nxt       = ptr_r;
    res_stat_nxt  = res_stat_r;
    res_slot_nxt  = res_slot_r;
    ov_nxt        = ov_r && out_stall;
    os_nxt        = os_r;
    oslot_nxt     = oslot_r;
    ocode_nxt     = ocode_r;
    olast_nxt     = olast_r;
    cmd           = '{op: CMD_IDLE, code: code_r, delay: delay_r, period: period_r,
                      least: least_r, sel: 6'(in_slot_index)};
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt   = in_func;
          code_nxt   = in_task_code;
          delay_nxt  = in_first_delay;
          period_nxt = in_repeat_period;
          now_nxt    = in_now_ms;
          cnt_nxt    = '0;
          case (in_func)
            FUNC_ADD, FUNC_TICK: state_nxt = ST_SCAN;
            FUNC_DEL: begin
              state_nxt = ST_RESULT;
              if ({3'b000, in_slot_index} < 7'(SLOT_COUNT)) begin
                cmd.op       = CMD_DEL;
                res_stat_nxt = STAT_DELETED;
                res_slot_nxt = in_slot_index;
              end else begin
                res_stat_nxt = STAT_FAIL;
                res_slot_nxt = 4'd0;
              end
            end
            default: begin
              state_nxt    = ST_RESULT;
              res_stat_nxt = STAT_NONE;
              res_slot_nxt = 4'd0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (func_r == FUNC_ADD) begin
          cmd.op = CMD_ADD;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_END) begin
          state_nxt    = ST_RESULT;
          res_slot_nxt = 4'd0;
          if (func_r == FUNC_ADD) begin
            res_stat_nxt = tail.hit ? STAT_ADDED : STAT_FAIL;
            res_slot_nxt = tail.hit ? tail.idx[3:0] : 4'd0;
          end else if (!tail.any || (now_r - last_time_r) < tail.least) begin
            res_stat_nxt = STAT_NONE;
          end else begin
            least_nxt     = tail.least;
            last_time_nxt = now_r;
            state_nxt     = ST_SUB;
          end
        end
      end
      ST_SUB: begin
        cmd.op    = CMD_SUB;
        cnt_nxt   = '0;
        state_nxt = ST_COUNT;
      end
      ST_COUNT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_END) begin
          total_nxt = (tail.fires > FIRE_W'(RESULT_CAP)) ? 5'(RESULT_CAP)
                                                          : tail.fires[4:0];
          sent_nxt  = '0;
          ptr_nxt   = '0;
          if (tail.fires == '0) begin
            res_stat_nxt = STAT_NONE;
            res_slot_nxt = 4'd0;
            state_nxt    = ST_RESULT;
          end else begin
            state_nxt = ST_REPORT;
          end
        end
      end
      ST_REPORT: begin
        if (!fire_vec[ptr_r]) begin
          ptr_nxt = ptr_r + 1'b1;
        end else if (out_free) begin
          ov_nxt    = 1'b1;
          os_nxt    = STAT_FIRED;
          oslot_nxt = 4'(ptr_r);
          ocode_nxt = code_vec[ptr_r];
          olast_nxt = last_one;
          sent_nxt  = sent_r + 1'b1;
          ptr_nxt   = ptr_r + 1'b1;
          if (last_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          os_nxt    = res_stat_r;
          oslot_nxt = res_slot_r;
          ocode_nxt = 8'd0;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ov_r        <= 1'b0;
      last_time_r <= 32'd0;
    end else begin
      state_r     <= state_nxt;
      ov_r        <= ov_nxt;
      last_time_r <= last_time_nxt;
    end
    cnt_r      <= cnt_nxt;
    func_r     <= func_nxt;
    code_r     <= code_nxt;
    delay_r    <= delay_nxt;
    period_r   <= period_nxt;
    now_r      <= now_nxt;
    least_r    <= least_nxt;
    total_r    <= total_nxt;
    sent_r     <= sent_nxt;
    ptr_r      <= ptr_nxt;
    res_stat_r <= res_stat_nxt;
    res_slot_r <= res_slot_nxt;
    os_r       <= os_nxt;
    oslot_r    <= oslot_nxt;
    ocode_r    <= ocode_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_slot_out    = oslot_r;
  assign out_code_out    = ocode_r;
  assign out_last_result = olast_r;

`ifndef SYNTHESIS
  a_sub_then_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUB |=> state_r == ST_COUNT)
    else $error("subtract not followed by fire count");

  a_report_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_REPORT |-> sent_r < total_r)
    else $error("reported more fires than counted");

  a_report_fire: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_REPORT && fire_vec[ptr_r] && out_free |=>
      out_valid && out_status == STAT_FIRED)
    else $error("fired slot not transferred to output");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("accepted item left no work");
`endif

endmodule

/* design/dts_cell.sv */
module dts_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dts_pkg::cell_cmd_t cmd,
  input  dts_pkg::link_t     link_i,
  output dts_pkg::link_t     link_o,
  output logic              fire_o,
  output logic [7:0]        code_o
);
  import dts_pkg::*;

  logic        valid_r, valid_nxt;
  logic        fire_r, fire_nxt;
  logic [31:0] delay_r, delay_nxt;
  logic [31:0] period_r, period_nxt;
  logic [7:0]  code_r, code_nxt;
  link_t       link_r, link_nxt;
  logic [31:0] diff;

  always_comb begin
    link_nxt = link_i;
    if (valid_r) begin
      link_nxt.any = 1'b1;
      if (!link_i.any || delay_r < link_i.least) begin
        link_nxt.least = delay_r;
      end
    end
    if (link_i.tok && !valid_r) begin
      link_nxt.tok = 1'b0;
      link_nxt.hit = 1'b1;
      link_nxt.idx = SLOT_MAX_W'(IDX);
    end
    link_nxt.fires = link_i.fires + FIRE_W'(fire_r);
  end

  always_comb begin
    valid_nxt  = valid_r;
    fire_nxt   = fire_r;
    delay_nxt  = delay_r;
    period_nxt = period_r;
    code_nxt   = code_r;
    diff       = delay_r - cmd.least;
    case (cmd.op)
      CMD_ADD: begin
        // claim the slot when the search token reaches a free cell
        if (link_i.tok && !valid_r) begin
          valid_nxt  = 1'b1;
          delay_nxt  = cmd.delay;
          period_nxt = cmd.period;
          code_nxt   = cmd.code;
        end
      end
      CMD_DEL: begin
        if (cmd.sel == SLOT_MAX_W'(IDX)) begin
          valid_nxt = 1'b0;
        end
      end
      CMD_SUB: begin
        fire_nxt = 1'b0;
        if (valid_r) begin
          if (diff == 32'd0) begin
            fire_nxt  = 1'b1;
            delay_nxt = period_r;
            valid_nxt = (period_r != 32'd0);
          end else begin
            delay_nxt = diff;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      fire_r  <= 1'b0;
      link_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      fire_r  <= fire_nxt;
      link_r  <= link_nxt;
    end
    delay_r  <= delay_nxt;
    period_r <= period_nxt;
    code_r   <= code_nxt;
  end

  assign link_o  = link_r;
  assign fire_o  = fire_r;
  assign code_o  = code_r;

endmodule

/* tb/delta_task_scheduler_tb.sv */
module delta_task_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dts_pkg::*;

  localparam int NSLOT = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam int RAND_ITEMS = 210;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  code;
    logic [31:0] delay;
    logic [31:0] period;
    logic [3:0]  idx;
    logic [31:0] now;
  } sched_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot;
    logic [7:0] code;
    logic       last;
  } sched_rsp_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_func;
  logic [7:0] in_task_code;
  logic [31:0] in_first_delay;
  logic [31:0] in_repeat_period;
  logic [3:0] in_slot_index;
  logic [31:0] in_now_ms;
  logic out_valid;
  logic out_stall;
  logic [2:0] out_status;
  logic [3:0] out_slot_out;
  logic [7:0] out_code_out;
  logic out_last_result;

  sched_req_t pending_reqs[$];
  sched_rsp_t expected_rsps[$];
  int hold_until_drained;
  int errors;
  int idle_cycles;
  int n_sent;
  int n_fired;
  int in_gap;
  int out_gap;

  // Predictor state
  bit          m_valid[NSLOT];
  logic [31:0] m_delay[NSLOT];
  logic [31:0] m_period[NSLOT];
  logic [7:0]  m_code[NSLOT];
  logic [31:0] m_last_time;
  // Time base used by the stimulus
  logic [31:0] clock_ms;

  delta_task_scheduler #(.SLOT_COUNT(NSLOT)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_task_code(in_task_code),
    .in_first_delay(in_first_delay), .in_repeat_period(in_repeat_period),
    .in_slot_index(in_slot_index), .in_now_ms(in_now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_slot_out(out_slot_out),
    .out_code_out(out_code_out), .out_last_result(out_last_result)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic sched_rsp_t mk_rsp(logic [2:0] s, logic [3:0] sl, logic [7:0] c);
    sched_rsp_t r;
    r.status = s;
    r.slot = sl;
    r.code = c;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Compute the responses for one transfer and update the predicted table.
  task automatic predict_schedule(input sched_req_t q);
    sched_rsp_t rs[$];
    sched_rsp_t r;
    bit any;
    logic [31:0] least;
    rs.delete();
    case (q.func)
      FUNC_ADD: begin
        r = mk_rsp(STAT_FAIL, 4'd0, 8'd0);
        for (int i = 0; i < NSLOT; i++) begin
          if (!m_valid[i]) begin
            m_valid[i] = 1'b1;
            m_code[i] = q.code;
            m_delay[i] = q.delay;
            m_period[i] = q.period;
            r = mk_rsp(STAT_ADDED, i[3:0], 8'd0);
            break;
          end
        end
        rs.push_back(r);
      end
      FUNC_DEL: begin
        m_valid[q.idx] = 1'b0;
        rs.push_back(mk_rsp(STAT_DELETED, q.idx, 8'd0));
      end
      FUNC_TICK: begin
        any = 1'b0;
        least = '0;
        for (int i = 0; i < NSLOT; i++) begin
          if (m_valid[i] && (!any || m_delay[i] < least)) begin
            least = m_delay[i];
            any = 1'b1;
          end
        end
        if (any && (q.now - m_last_time) >= least) begin
          m_last_time = q.now;
          for (int i = 0; i < NSLOT; i++) begin
            if (m_valid[i]) begin
              m_delay[i] = m_delay[i] - least;
              if (m_delay[i] == 0) begin
                if (rs.size() < RESULT_CAP) rs.push_back(mk_rsp(STAT_FIRED, i[3:0], m_code[i]));
                if (m_period[i] != 0) m_delay[i] = m_period[i];
                else m_valid[i] = 1'b0;
              end
            end
          end
        end
        if (rs.size() == 0) rs.push_back(mk_rsp(STAT_NONE, 4'd0, 8'd0));
      end
      default: rs.push_back(mk_rsp(STAT_NONE, 4'd0, 8'd0));
    endcase
    rs[rs.size()-1].last = 1'b1;
    foreach (rs[k]) expected_rsps.push_back(rs[k]);
  endtask

  function automatic sched_req_t mk_req(logic [1:0] f, logic [7:0] c, logic [31:0] d,
                                        logic [31:0] p, logic [3:0] ix, logic [31:0] n);
    sched_req_t q;
    q.func = f; q.code = c; q.delay = d; q.period = p; q.idx = ix; q.now = n;
    return q;
  endfunction

  function automatic sched_req_t rand_req(logic [1:0] f);
    return mk_req(f, 8'($urandom), $urandom, $urandom, 4'($urandom), $urandom);
  endfunction

  // Hold marker: a request with func bits set to FUNC_TICK and this code is not used;
  // a separate counter selects the index at which the driver waits for drain.
  initial begin
    logic [31:0] d;
    sched_req_t q;
    int sel;
    hold_until_drained = -1;
    // Directed: empty tick, undefined op, delete, adds incl. extreme fields, full table
    pending_reqs.push_back(mk_req(FUNC_TICK, 8'hff, '1, '1, 4'hf, 32'd5));
    pending_reqs.push_back(mk_req(2'd3, 8'hff, '1, '1, 4'hf, '1));
    pending_reqs.push_back(mk_req(FUNC_DEL, 8'h00, '0, '0, 4'd7, '0));
    pending_reqs.push_back(mk_req(FUNC_ADD, 8'h00, 32'd0, 32'd0, 4'hf, '1));
    pending_reqs.push_back(mk_req(FUNC_ADD, 8'hff, '1, '1, 4'h0, '0));
    for (int i = 0; i < 14; i++)
      pending_reqs.push_back(mk_req(FUNC_ADD, 8'(i * 17 + 3), 32'd0, 32'(i % 3), 4'(i), '0));
    pending_reqs.push_back(mk_req(FUNC_ADD, 8'h5a, 32'd1, 32'd1, 4'd0, '0));
    // All zero-delay slots fire at once; large elapsed with wrap
    pending_reqs.push_back(mk_req(FUNC_TICK, 8'd0, '0, '0, 4'd0, 32'hffff_fff0));
    pending_reqs.push_back(mk_req(FUNC_TICK, 8'd0, '0, '0, 4'd0, 32'h0000_0010));
    pending_reqs.push_back(mk_req(FUNC_DEL, 8'd0, '0, '0, 4'd1, '0));
    pending_reqs.push_back(mk_req(FUNC_DEL, 8'd0, '0, '0, 4'd15, '0));
    hold_until_drained = pending_reqs.size();
    // Random part: adds with mostly small delays, deletes, rising time checks, undefined ops
    clock_ms = 32'h0000_0010;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        q = rand_req(FUNC_ADD);
        if ($urandom_range(0, 9) != 0) begin
          q.delay = $urandom_range(0, 8);
          q.period = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
        end
      end else if (sel < 55) begin
        q = rand_req(FUNC_DEL);
      end else if (sel < 95) begin
        q = rand_req(FUNC_TICK);
        d = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, 5));
        clock_ms = clock_ms + d;
        q.now = clock_ms;
      end else begin
        q = rand_req(2'd3);
      end
      pending_reqs.push_back(q);
    end
  end

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 2;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_schedule(mk_req(in_func, in_task_code, in_first_delay, in_repeat_period,
                                in_slot_index, in_now_ms));
        n_sent = n_sent + 1;
      end
      // drop valid during a gap or the drain hold
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_reqs.size() == 0 ||
                   (n_sent == hold_until_drained && expected_rsps.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        {in_func, in_task_code, in_first_delay, in_repeat_period, in_slot_index, in_now_ms}
          <= pending_reqs.pop_front();
        in_gap <= (n_sent > 40 && n_sent < 80) ? 0 : pick_gap();
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    sched_rsp_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected transfer: status %0d slot %0d", out_status, out_slot_out);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (out_status == STAT_FIRED) n_fired++;
          if (out_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status); errors++;
          end
          if (out_slot_out !== e.slot) begin
            $error("slot_out: expected %0d, got %0d", e.slot, out_slot_out); errors++;
          end
          if (out_code_out !== e.code) begin
            $error("code_out: expected %0d, got %0d", e.code, out_code_out); errors++;
          end
          if (out_last_result !== e.last) begin
            $error("last_result: expected %0d, got %0d", e.last, out_last_result); errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap <= out_gap - 1;
      end else begin
        out_stall <= 1'b0;
        out_gap <= (n_sent > 120 && n_sent < 150) ? 0 : pick_gap();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("delta_task_scheduler_tb: done, errors");
      $finish;
    end
  end

  initial begin
    errors = 0;
    n_sent = 0;
    n_fired = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = '0;
    in_task_code = '0;
    in_first_delay = '0;
    in_repeat_period = '0;
    in_slot_index = '0;
    in_now_ms = '0;
    out_stall = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      m_valid[i] = 1'b0;
      m_delay[i] = '0;
      m_period[i] = '0;
      m_code[i] = '0;
    end
    m_last_time = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0 && !in_valid && n_sent > 0);
    wait (expected_rsps.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d transfers in, %0d task fires, full table, wrap and stalls",
             n_sent, n_fired);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("delta_task_scheduler_tb: done, clean");
    end else begin
      $display("delta_task_scheduler_tb: done, errors");
    end
    $finish;
  end

endmodule

/* delta_task_scheduler.f */
design/dts_pkg.sv
design/dts_cell.sv
design/delta_task_scheduler.sv
tb/delta_task_scheduler_tb.sv
